// ===== hw/rtl/pip_pkg.sv =====
// Shared widths and opcode codes for the point-in-polygon crossing block.
`timescale 1ns / 1ps
`default_nettype none
package pip_pkg;

	// Field widths of the request and configuration channels
	localparam int OPCODE_W = 2;
	localparam int SLOT_W   = 6;
	localparam int COORD_W  = 16;
	localparam int VIDX_W   = 6;
	localparam int ECNT_W   = 7;

	// Width used to compare table indices against table depths (depths up to 8191)
	localparam int PTR_W = 13;

	// Request opcodes
	localparam logic [OPCODE_W-1:0] OP_WR_VERTEX = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WR_EDGE   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_QUERY     = 2'd2;

endpackage
`default_nettype wire

// ===== hw/rtl/pip_req_if.sv =====
// Request channel: table writes and query points.
`timescale 1ns / 1ps
`default_nettype none
interface pip_req_if;
	logic                                valid;
	logic                                ready;
	logic [pip_pkg::OPCODE_W-1:0]        opcode;
	logic [pip_pkg::SLOT_W-1:0]          slot;
	logic signed [pip_pkg::COORD_W-1:0]  coord_x;
	logic signed [pip_pkg::COORD_W-1:0]  coord_y;
	logic [pip_pkg::VIDX_W-1:0]          edge_from;
	logic [pip_pkg::VIDX_W-1:0]          edge_to;

	modport source (output valid, opcode, slot, coord_x, coord_y, edge_from, edge_to,
		input ready);
	modport sink (input valid, opcode, slot, coord_x, coord_y, edge_from, edge_to,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pip_res_if.sv =====
// Result channel: one inside/outside flag per query.
`timescale 1ns / 1ps
`default_nettype none
interface pip_res_if;
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, inside_res, input ready);
	modport sink (input valid, inside_res, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/pip_cfg_if.sv =====
// Configuration write channel: carries the edge count register value.
`timescale 1ns / 1ps
`default_nettype none
interface pip_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pip_pkg::ECNT_W-1:0]   edge_count;

	modport source (output valid, edge_count, input ready);
	modport sink (input valid, edge_count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/point_in_polygon_crossing.sv =====
// Even-odd ray-casting point-in-polygon engine over stored vertex and edge tables.
//
// Usage:
//   req  - one request each handshake: opcode selects vertex write, edge write
//          or query point. Writes give no result; an
//          out-of-range slot or an unused opcode is dropped.
//   res  - one inside_res flag per query (1 when the crossing count is odd).
//   cfg  - writes the edge_count register; always ready. Write it only while
//          no query is in flight.
// Throughput:
//   A query walks edges 0 .. n-1 (n = edge_count, capped at MAX_EDGES), one
//   edge per cycle through a five-stage read/compute pipeline: edge table
//   read, dual-port vertex table read, differences, products, compare.
//   req is not ready from the acceptance of a query until its result is
//   loaded into the output register.
// Reset: control state, the pipeline valids and edge_count clear; table
//   contents are undefined until written.
// Stall: the result sits in an output register; a new request is taken while
//   it waits, and a following query holds its final result until res drains.
`timescale 1ns / 1ps
`default_nettype none
module point_in_polygon_crossing #(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	pip_req_if.sink   req,
	pip_res_if.source res,
	pip_cfg_if.sink   cfg
);

	localparam int CW = pip_pkg::COORD_W;
	localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int NW = $clog2(MAX_EDGES + 1);
	localparam int PW = pip_pkg::PTR_W;

	// Endpoint reduction table: raw 6-bit vertex index modulo the table depth
	typedef logic [VW-1:0] vmod_tab_t [2**pip_pkg::VIDX_W];

	function automatic vmod_tab_t mk_vmod_tab();
		vmod_tab_t t;
		for (int i = 0; i < 2**pip_pkg::VIDX_W; i++) begin
			t[i] = VW'(i % MAX_VERTICES);
		end
		return t;
	endfunction

	localparam vmod_tab_t VMOD_TAB = mk_vmod_tab();

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	// Tables
	logic [2*CW-1:0] vtx_mem  [MAX_VERTICES];
	logic [2*VW-1:0] edge_mem [MAX_EDGES];

	state_t              state_q;
	logic [pip_pkg::ECNT_W-1:0] edge_count_q;
	logic [NW-1:0]       cnt_q;
	logic [NW-1:0]       n_q;
	logic                parity_q;
	logic                out_valid_q;
	logic                inside_q;
	logic signed [CW-1:0] px_q;
	logic signed [CW-1:0] py_q;

	logic                req_fire;
	logic                issue;
	logic [PW-1:0]       slot_ext;
	logic [PW-1:0]       ecnt_ext;
	logic [NW-1:0]       n_sel;
	logic                pipe_busy;
	logic                res_load;

	// Pipeline registers
	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [2*VW-1:0]     edge_s1;
	logic [2*CW-1:0]     va_s2, vb_s2;
	logic signed [CW:0]  dxp_s3, dy_s3, dxb_s3, dyp_s3;
	logic                cross_s3, cross_s4;
	logic                pos_s3, pos_s4;
	logic signed [2*CW+1:0] lhs_s4, rhs_s4;

	// Combinational values: stage 2 endpoint coordinates and the stage 4 compare
	logic signed [CW-1:0] ax, ay, bx, by;
	logic                 hit;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign res.valid = out_valid_q;
	assign res.inside_res = inside_q;

	assign slot_ext  = PW'(req.slot);
	assign ecnt_ext  = PW'(edge_count_q);
	assign n_sel     = (ecnt_ext > PW'(MAX_EDGES)) ? NW'(MAX_EDGES) : NW'(ecnt_ext);
	assign issue     = (state_q == ST_RUN) && (cnt_q != n_q);
	assign pipe_busy = valid_s1 || valid_s2 || valid_s3 || valid_s4;
	assign res_load  = (state_q == ST_DONE) && !pipe_busy && (!out_valid_q || res.ready);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_count_q <= '0;
		end else if (cfg.valid) begin
			edge_count_q <= cfg.edge_count;
		end
	end

	// Table writes from accepted requests
	always_ff @(posedge clk) begin
		if (req_fire && req.opcode == pip_pkg::OP_WR_VERTEX
				&& slot_ext < PW'(MAX_VERTICES)) begin
			vtx_mem[slot_ext[VW-1:0]] <= {req.coord_x, req.coord_y};
		end
		if (req_fire && req.opcode == pip_pkg::OP_WR_EDGE
				&& slot_ext < PW'(MAX_EDGES)) begin
			edge_mem[slot_ext[EW-1:0]] <= {VMOD_TAB[req.edge_from], VMOD_TAB[req.edge_to]};
		end
	end

	// Stage 1: read the edge entry; stage 2: read both endpoints
	always_ff @(posedge clk) begin
		edge_s1 <= edge_mem[cnt_q[EW-1:0]];
		va_s2   <= vtx_mem[edge_s1[2*VW-1:VW]];
		vb_s2   <= vtx_mem[edge_s1[VW-1:0]];
	end

	assign ax = va_s2[2*CW-1:CW];
	assign ay = va_s2[CW-1:0];
	assign bx = vb_s2[2*CW-1:CW];
	assign by = vb_s2[CW-1:0];

	// Stage 3: differences and straddle test; stage 4: cross products
	always_ff @(posedge clk) begin
		dxp_s3   <= (CW+1)'(px_q) - (CW+1)'(ax);
		dy_s3    <= (CW+1)'(by) - (CW+1)'(ay);
		dxb_s3   <= (CW+1)'(bx) - (CW+1)'(ax);
		dyp_s3   <= (CW+1)'(py_q) - (CW+1)'(ay);
		cross_s3 <= (ay > py_q) != (by > py_q);
		pos_s3   <= (by > ay);
		lhs_s4   <= dxp_s3 * dy_s3;
		rhs_s4   <= dxb_s3 * dyp_s3;
		cross_s4 <= cross_s3;
		pos_s4   <= pos_s3;
	end

	// Compare with the sign of the edge direction folded in
	assign hit = pos_s4 ? (lhs_s4 < rhs_s4) : (rhs_s4 < lhs_s4);

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Query latch
	always_ff @(posedge clk) begin
		if (req_fire && req.opcode == pip_pkg::OP_QUERY) begin
			px_q <= req.coord_x;
			py_q <= req.coord_y;
		end
	end

	// Sequencer: accept, walk edges, drain, hand result to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
			inside_q    <= 1'b0;
		end else begin
			// Load a finished answer, or drop a result the receiver has taken
			if (res_load) begin
				out_valid_q <= 1'b1;
				inside_q    <= parity_q;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (valid_s4 && cross_s4 && hit) begin
				parity_q <= ~parity_q;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req.opcode == pip_pkg::OP_QUERY) begin
						cnt_q    <= '0;
						n_q      <= n_sel;
						parity_q <= 1'b0;
						state_q  <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == n_q) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + NW'(1);
					end
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sim/pip_checker.sv =====
// Watches the request, result and config channels, predicts each query answer and compares.
`timescale 1ns / 1ps
module pip_checker (
	input  logic clk,
	input  logic arst_n,
	pip_req_if   req,
	pip_res_if   res,
	pip_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	localparam int VERT_DEPTH = 64;
	localparam int EDGE_DEPTH = 64;

	// Shadow copy of the block's tables and edge count register
	logic signed [pip_pkg::COORD_W-1:0] vert_x [VERT_DEPTH];
	logic signed [pip_pkg::COORD_W-1:0] vert_y [VERT_DEPTH];
	logic [pip_pkg::VIDX_W-1:0]         edge_a [EDGE_DEPTH];
	logic [pip_pkg::VIDX_W-1:0]         edge_b [EDGE_DEPTH];
	bit [pip_pkg::ECNT_W-1:0]           edge_total;

	// Expected inside flags, oldest first
	bit inside_queue [$];
	int result_seq;

	// Walk the active edges and return the parity of the ray crossings
	function automatic bit crossing_parity(input logic signed [pip_pkg::COORD_W-1:0] px,
		input logic signed [pip_pkg::COORD_W-1:0] py);
		int     span;
		bit     parity;
		bit     hit;
		longint ax, ay, bx, by, dy, lhs, rhs;
		span = (edge_total > EDGE_DEPTH) ? EDGE_DEPTH : edge_total;
		parity = 1'b0;
		for (int i = 0; i < span; i++) begin
			ax = vert_x[edge_a[i]];
			ay = vert_y[edge_a[i]];
			bx = vert_x[edge_b[i]];
			by = vert_y[edge_b[i]];
			// Only an edge that straddles the ray line can cross it
			if ((ay > py) != (by > py)) begin
				dy  = by - ay;
				lhs = (px - ax) * dy;
				rhs = (bx - ax) * (py - ay);
				hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
				parity ^= hit;
			end
		end
		return parity;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		bit want;
		bit predicted;
		if (!arst_n) begin
			edge_total = '0;
			inside_queue.delete();
			pending = 0;
		end else begin
			// Compare a delivered result with the oldest expectation
			if (res.valid && res.ready) begin
				if (inside_queue.size() == 0) begin
					$display("%0t: unexpected result, expected none actual inside_res=%0b",
						$time, res.inside_res);
					fail_count++;
				end else begin
					want = inside_queue.pop_front();
					if (res.inside_res !== want) begin
						$display("%0t: result %0d inside_res mismatch, expected %0b actual %0b",
							$time, result_seq, want, res.inside_res);
						fail_count++;
					end
				end
				result_seq++;
			end

			if (cfg.valid && cfg.ready)
				edge_total = cfg.edge_count;

			// Apply an accepted request to the shadow state
			if (req.valid && req.ready) begin
				case (req.opcode)
					pip_pkg::OP_WR_VERTEX: begin
						vert_x[req.slot] = req.coord_x;
						vert_y[req.slot] = req.coord_y;
					end
					pip_pkg::OP_WR_EDGE: begin
						edge_a[req.slot] = req.edge_from;
						edge_b[req.slot] = req.edge_to;
					end
					pip_pkg::OP_QUERY: begin
						predicted = crossing_parity(req.coord_x, req.coord_y);
						inside_queue = {inside_queue, predicted};
					end
					default: begin
						// unused opcode: drop
					end
				endcase
			end
			pending = inside_queue.size();
		end
	end
endmodule

// ===== sim/point_in_polygon_crossing_tb.sv =====
// Testbench top: clock, reset, request and config stimulus, result back-pressure, verdict.
`timescale 1ns / 1ps
module point_in_polygon_crossing_tb;
	import pip_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int TARGET_ITEMS  = 1300;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 80;
	localparam int VERT_DEPTH    = 64;
	localparam int EDGE_DEPTH    = 64;
	localparam int SCALE_NEAR    = 64;
	localparam int SCALE_MID     = 3000;
	localparam int SCALE_FULL    = 32767;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_e;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int pending;
	int cycle_count;

	pip_req_if req_ch ();
	pip_res_if res_ch ();
	pip_cfg_if cfg_ch ();

	point_in_polygon_crossing u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	pip_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.res        (res_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #CLK_HALF clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Result receiver: random stall patterns plus an occasional long hold-off
	bit       hold_req;
	int       hold_left;
	int       seg_left;
	rx_mode_e rx_mode;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
			res_ch.ready <= 1'b0;
		end else begin
			if (seg_left == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				seg_left = $urandom_range(8, 80);
			end
			seg_left--;
			case (rx_mode)
				RX_OPEN:   res_ch.ready <= 1'b1;
				RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   res_ch.ready <= ~res_ch.ready;
			endcase
		end
	end

	// Which table entries hold data whose reads are safe
	bit                        vert_ok [VERT_DEPTH];
	bit                        edge_ok [EDGE_DEPTH];
	logic signed [COORD_W-1:0] vert_x_seen [VERT_DEPTH];
	logic signed [COORD_W-1:0] vert_y_seen [VERT_DEPTH];
	int                        active_edges;
	int                        items_sent;
	int                        burst_left;

	function automatic logic [5:0] rnd6();
		return 6'($urandom());
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord(input int scale);
		if (scale >= SCALE_FULL)
			return 16'($urandom());
		return 16'(int'($urandom_range(0, 2 * scale)) - scale);
	endfunction

	function automatic logic [5:0] pick_vertex();
		logic [5:0] idx;
		idx = rnd6();
		while (!vert_ok[idx])
			idx = rnd6();
		return idx;
	endfunction

	function automatic bit queries_safe();
		for (int i = 0; i < active_edges; i++)
			if (!edge_ok[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Offer one request in bursts with random gaps; return once it is accepted
	task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SLOT_W-1:0] slot,
		input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
		input logic [VIDX_W-1:0] from_v, input logic [VIDX_W-1:0] to_v);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			gap = $urandom_range(1, 10);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		burst_left--;
		req_ch.opcode    <= op;
		req_ch.slot      <= slot;
		req_ch.coord_x   <= x;
		req_ch.coord_y   <= y;
		req_ch.edge_from <= from_v;
		req_ch.edge_to   <= to_v;
		req_ch.valid     <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		case (op)
			OP_WR_VERTEX: begin
				vert_ok[slot] = 1'b1;
				vert_x_seen[slot] = x;
				vert_y_seen[slot] = y;
			end
			OP_WR_EDGE: edge_ok[slot] = vert_ok[from_v] && vert_ok[to_v];
			default: ;
		endcase
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	task automatic send_query(input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y);
		send_item(OP_QUERY, rnd6(), x, y, rnd6(), rnd6());
	endtask

	task automatic send_vertex(input logic [SLOT_W-1:0] slot,
		input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		send_item(OP_WR_VERTEX, slot, x, y, rnd6(), rnd6());
	endtask

	task automatic send_edge(input logic [SLOT_W-1:0] slot, input logic [VIDX_W-1:0] from_v,
		input logic [VIDX_W-1:0] to_v);
		send_item(OP_WR_EDGE, slot, rand_coord(SCALE_FULL), rand_coord(SCALE_FULL), from_v, to_v);
	endtask

	task automatic send_noise();
		send_item(OP_UNUSED, rnd6(), rand_coord(SCALE_FULL), rand_coord(SCALE_FULL),
			rnd6(), rnd6());
	endtask

	// Stop offering and wait until every expected result has been delivered
	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_edge_total(input logic [ECNT_W-1:0] value);
		drain();
		cfg_ch.edge_count <= value;
		cfg_ch.valid      <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		active_edges = (value > EDGE_DEPTH) ? EDGE_DEPTH : value;
	endtask

	// Random query point: on a vertex, on a vertex's y line, near the shape, or anywhere
	task automatic random_query(input int scale);
		logic [5:0] v;
		v = pick_vertex();
		case ($urandom_range(0, 3))
			0: send_query(vert_x_seen[v], vert_y_seen[v]);
			1: send_query(rand_coord(scale), vert_y_seen[v]);
			2: send_query(rand_coord(scale), rand_coord(scale));
			default: send_query(rand_coord(SCALE_FULL), rand_coord(SCALE_FULL));
		endcase
	endtask

	// One polygon: set the edge count, load vertices and edges, then query it
	task automatic run_polygon(input int set_idx);
		int r, n, verts, base, scale, shape, nq;
		case (set_idx)
			0: n = 127;
			1: n = 64;
			2: n = 0;
			default: begin
				r = $urandom_range(0, 99);
				if (r < 5)
					n = 0;
				else if (r < 12)
					n = 64;
				else if (r < 17)
					n = $urandom_range(65, 127);
				else if (r < 27)
					n = $urandom_range(13, 63);
				else
					n = $urandom_range(1, 12);
			end
		endcase
		write_edge_total(7'(n));
		verts = (active_edges < 3) ? 3 : active_edges;
		base  = $urandom_range(0, VERT_DEPTH - 1);
		case ($urandom_range(0, 2))
			0: scale = SCALE_NEAR;
			1: scale = SCALE_MID;
			default: scale = SCALE_FULL;
		endcase
		shape = $urandom_range(0, 3);

		// Load the vertices, with the odd stray item mixed in
		for (int i = 0; i < verts; i++) begin
			send_vertex(6'((base + i) % VERT_DEPTH), rand_coord(scale), rand_coord(scale));
			if ($urandom_range(0, 15) == 0)
				send_noise();
			if ($urandom_range(0, 19) == 0 && queries_safe())
				random_query(scale);
		end

		// Load the edges: a closed ring or random chords
		for (int i = 0; i < active_edges; i++) begin
			if (shape == 0)
				send_edge(6'(i), pick_vertex(), pick_vertex());
			else
				send_edge(6'(i), 6'((base + i) % VERT_DEPTH),
					6'((base + (i + 1) % verts) % VERT_DEPTH));
			if ($urandom_range(0, 19) == 0 && queries_safe())
				random_query(scale);
		end

		if (set_idx == 3 || $urandom_range(0, 11) == 0)
			hold_req = 1'b1;

		nq = $urandom_range(4, 24);
		for (int j = 0; j < nq; j++) begin
			case ($urandom_range(0, 11))
				0: send_noise();
				1: send_vertex(rnd6(), rand_coord(scale), rand_coord(scale));
				2: send_edge(rnd6(), pick_vertex(), pick_vertex());
				3: begin
					if ($urandom_range(0, 3) == 0)
						drain();
					random_query(scale);
				end
				default: random_query(scale);
			endcase
		end
	endtask

	initial begin : stimulus
		int set_idx;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_WR_VERTEX;
		req_ch.slot       = '0;
		req_ch.coord_x    = '0;
		req_ch.coord_y    = '0;
		req_ch.edge_from  = '0;
		req_ch.edge_to    = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.edge_count = '0;
		res_ch.ready      = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero edge count straight after reset
		send_query(16'sd0, 16'sd0);
		send_query(-16'sd32768, 16'sd32767);

		// Full-range square on corner slots
		send_vertex(6'd0,  -16'sd32768, -16'sd32768);
		send_vertex(6'd21,  16'sd32767, -16'sd32768);
		send_vertex(6'd63,  16'sd32767,  16'sd32767);
		send_vertex(6'd42, -16'sd32768,  16'sd32767);
		send_edge(6'd0, 6'd0,  6'd21);
		send_edge(6'd1, 6'd21, 6'd63);
		send_edge(6'd2, 6'd63, 6'd42);
		send_edge(6'd3, 6'd42, 6'd0);
		send_noise();
		write_edge_total(7'd4);
		send_query(16'sd0, 16'sd0);
		send_query(-16'sd32768, 16'sd0);
		send_query(16'sd32767, 16'sd0);
		send_query(16'sd0, -16'sd32768);
		send_query(16'sd0, 16'sd32767);
		send_query(-16'sd32768, -16'sd32768);

		// Degenerate edge whose endpoints coincide
		send_edge(6'd4, 6'd21, 6'd21);
		write_edge_total(7'd5);
		send_query(16'sd32767, -16'sd32768);
		send_query(-16'sd1, 16'sd32766);

		set_idx = 0;
		while (items_sent < TARGET_ITEMS) begin
			run_polygon(set_idx);
			set_idx++;
		end

		// Wait out the tail, then report
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
